FILE: design/vefc_pkg.sv
// Shared widths, register indexes, lane codes and pipeline context types of the edge clipper.
package vefc_pkg;

  localparam int COORD_W = 32;
  localparam int PT_W = 34;
  localparam int WIDE_W = 66;
  localparam int LINE_W = 19;
  localparam int FRAME_W = 16;
  localparam int CFG_IDX_W = 8;
  localparam int MAG_W = 33;
  localparam int NUM_W = 63;
  localparam int QUO_W = NUM_W + 1;
  localparam int MD_LAT = NUM_W + 3;

  localparam int DEF_COORD_FRAC_BITS = 8;
  localparam int DEF_SITE_INDEX_BITS = 16;

  localparam logic [FRAME_W-1:0] FRAME_RESET = 16'd1023;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_MAX_X = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_MAX_Y = 8'd1;

  localparam logic [2:0] K_PASS = 3'd0;
  localparam logic [2:0] K_FIN  = 3'd1;
  localparam logic [2:0] K_SP   = 3'd2;
  localparam logic [2:0] K_SN   = 3'd3;
  localparam logic [2:0] K_EP   = 3'd4;
  localparam logic [2:0] K_EN   = 3'd5;

  typedef logic signed [PT_W-1:0] pt_t;
  typedef logic signed [WIDE_W-1:0] wide_t;
  typedef logic signed [QUO_W-1:0] quo_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       frame;
    logic       xout;
    logic       yout;
    pt_t        px;
    pt_t        py;
    pt_t        xedge;
    pt_t        n2;
    pt_t        d2;
  } ctx1_t;

  typedef struct packed {
    logic  use2;
    logic  sub;
    logic  frame;
    pt_t   xb;
    wide_t x_mid;
    wide_t y_mid;
  } ctx2_t;

endpackage

FILE: design/voronoi_edge_frame_clipper.sv
// Top level of the Voronoi edge clipper: brings one edge per clock into the frame.
//
// One edge is taken in every clock cycle (busy stays low) and its clipped result appears on
// the output ports with done high for one cycle. The pipeline is two multiply-divide units in
// series, each of 66 stages, whose divide steps each give one quotient bit. An edge with both
// ends absent gives no result. The frame registers are written through the cfg port, which is
// always ready; write them only while no edge is in flight. The receiver cannot stall the
// results.
module voronoi_edge_frame_clipper import vefc_pkg::*; #(
  parameter int COORD_FRAC_BITS = DEF_COORD_FRAC_BITS,
  parameter int SITE_INDEX_BITS = DEF_SITE_INDEX_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [FRAME_W-1:0]            cfg_data,
  input  logic                          start,
  output logic                          busy,
  input  logic                          start_present,
  input  logic signed [COORD_W-1:0]     start_x_in,
  input  logic signed [COORD_W-1:0]     start_y_in,
  input  logic signed [SITE_INDEX_BITS:0] start_site_in,
  input  logic                          end_present,
  input  logic signed [COORD_W-1:0]     end_x_in,
  input  logic signed [COORD_W-1:0]     end_y_in,
  input  logic signed [SITE_INDEX_BITS:0] end_site_in,
  input  logic signed [LINE_W-1:0]      line_a,
  input  logic signed [LINE_W-1:0]      line_b,
  output logic                          done,
  output logic signed [COORD_W-1:0]     start_x,
  output logic signed [COORD_W-1:0]     start_y,
  output logic signed [COORD_W-1:0]     end_x,
  output logic signed [COORD_W-1:0]     end_y,
  output logic signed [SITE_INDEX_BITS:0] start_site,
  output logic signed [SITE_INDEX_BITS:0] end_site,
  output logic                          inside_res
);

  localparam int SITE_W = SITE_INDEX_BITS + 1;
  localparam wide_t COORD_MAXW = (wide_t'(1) <<< (COORD_W - 1)) - wide_t'(1);
  localparam wide_t COORD_MINW = -(wide_t'(1) <<< (COORD_W - 1));

  function automatic logic signed [COORD_W-1:0] sat32(input wide_t v);
    if (v > COORD_MAXW) begin
      return COORD_MAXW[COORD_W-1:0];
    end else if (v < COORD_MINW) begin
      return COORD_MINW[COORD_W-1:0];
    end
    return v[COORD_W-1:0];
  endfunction

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;

  logic [FRAME_W-1:0] frame_max_x, frame_max_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_max_x <= FRAME_RESET;
      frame_max_y <= FRAME_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == REG_FRAME_MAX_X) begin
        frame_max_x <= cfg_data;
      end else if (cfg_index == REG_FRAME_MAX_Y) begin
        frame_max_y <= cfg_data;
      end
    end
  end

  pt_t mx, my;
  wide_t mxw, myw;
  assign mx = pt_t'({frame_max_x, {COORD_FRAC_BITS{1'b0}}});
  assign my = pt_t'({frame_max_y, {COORD_FRAC_BITS{1'b0}}});
  assign mxw = wide_t'(mx);
  assign myw = wide_t'(my);

  // Input register.
  logic v0, sp0, ep0;
  logic signed [COORD_W-1:0] xs0, ys0, xe0, ye0;
  logic [2*SITE_W-1:0] site0;
  logic signed [LINE_W-1:0] a0, b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= start & ~busy & (start_present | end_present);
    end
  end

  always_ff @(posedge clk) begin
    sp0 <= start_present;
    ep0 <= end_present;
    xs0 <= start_x_in;
    ys0 <= start_y_in;
    xe0 <= end_x_in;
    ye0 <= end_y_in;
    site0 <= {end_site_in, start_site_in};
    a0 <= line_a;
    b0 <= line_b;
  end

  // Lane setup: lane 0 is the start vertex, lane 1 the end vertex.
  pt_t xs, ys, xe, ye, dx, dy, na, bb;
  logic pos;
  ctx1_t [1:0] c1_n, c1;
  pt_t q1_n [2];
  pt_t n1_n [2];
  pt_t d1_n [2];
  pt_t q1 [2];
  pt_t n1 [2];
  pt_t d1 [2];
  logic [2*SITE_W-1:0] site1;
  logic v1;

  assign xs = pt_t'(xs0);
  assign ys = pt_t'(ys0);
  assign xe = pt_t'(xe0);
  assign ye = pt_t'(ye0);
  assign dx = xe - xs;
  assign dy = ye - ys;
  assign na = -pt_t'(a0);
  assign bb = pt_t'(b0);
  assign pos = (na > 0) == (bb > 0);

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      c1_n[i] = '0;
      q1_n[i] = '0;
      n1_n[i] = '0;
      d1_n[i] = '0;
    end
    c1_n[0].kind = K_PASS;
    c1_n[0].px = xs;
    c1_n[0].py = ys;
    c1_n[1].kind = K_PASS;
    c1_n[1].px = xe;
    c1_n[1].py = ye;
    if (sp0 && ep0) begin
      if (xs0 == xe0) begin
        for (int i = 0; i < 2; i++) begin
          c1_n[i].frame = (c1_n[i].py < 0) || (c1_n[i].py > my);
          if (c1_n[i].py < 0) begin
            c1_n[i].py = '0;
          end else if (c1_n[i].py > my) begin
            c1_n[i].py = my;
          end
        end
      end else begin
        for (int i = 0; i < 2; i++) begin
          c1_n[i].kind = K_FIN;
          c1_n[i].xout = (c1_n[i].px < 0) || (c1_n[i].px > mx);
          c1_n[i].yout = (c1_n[i].py < 0) || (c1_n[i].py > my);
          c1_n[i].xedge = (c1_n[i].px < 0) ? '0 : mx;
          c1_n[i].n2 = dx;
          c1_n[i].d2 = dy;
          q1_n[i] = c1_n[i].xedge - c1_n[i].px;
          n1_n[i] = dy;
          d1_n[i] = dx;
        end
      end
    end else if (!sp0) begin
      c1_n[0].frame = 1'b1;
      if (b0 == 0) begin
        c1_n[0].px = xe;
        c1_n[0].py = my;
      end else if (a0 == 0) begin
        c1_n[0].px = '0;
        c1_n[0].py = ye;
      end else begin
        c1_n[0].kind = pos ? K_SP : K_SN;
        c1_n[0].px = xe;
        c1_n[0].py = ye;
        c1_n[0].n2 = bb;
        c1_n[0].d2 = na;
        q1_n[0] = pos ? xe : -xe;
        n1_n[0] = na;
        d1_n[0] = bb;
      end
    end else begin
      c1_n[1].frame = 1'b1;
      if (b0 == 0) begin
        c1_n[1].px = xs;
        c1_n[1].py = '0;
      end else if (a0 == 0) begin
        c1_n[1].px = mx;
        c1_n[1].py = ys;
      end else begin
        c1_n[1].kind = pos ? K_EP : K_EN;
        c1_n[1].px = xs;
        c1_n[1].py = ys;
        c1_n[1].n2 = bb;
        c1_n[1].d2 = na;
        q1_n[1] = mx - xs;
        n1_n[1] = na;
        d1_n[1] = bb;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    c1 <= c1_n;
    site1 <= site0;
    for (int i = 0; i < 2; i++) begin
      q1[i] <= q1_n[i];
      n1[i] <= n1_n[i];
      d1[i] <= d1_n[i];
    end
  end

  // First multiply-divide pass.
  quo_t quo1 [2];
  for (genvar g = 0; g < 2; g++) begin : g_md1
    vefc_muldiv u_md1 (
      .clk (clk),
      .q   (q1[g]),
      .n   (n1[g]),
      .d   (d1[g]),
      .quo (quo1[g])
    );
  end

  ctx1_t [1:0] c1_dl [MD_LAT];
  logic [2*SITE_W-1:0] s1_dl [MD_LAT];
  logic [MD_LAT-1:0] v1_dl;

  always_ff @(posedge clk) begin
    c1_dl[0] <= c1;
    s1_dl[0] <= site1;
    for (int i = 1; i < MD_LAT; i++) begin
      c1_dl[i] <= c1_dl[i-1];
      s1_dl[i] <= s1_dl[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1_dl <= '0;
    end else begin
      v1_dl <= {v1_dl[MD_LAT-2:0], v1};
    end
  end

  // Decision after the first pass.
  ctx1_t cd;
  wide_t pxw, pyw, tw, y1, x1, yel;
  logic fix;
  ctx2_t [1:0] c2_n, c2;
  pt_t q2_n [2];
  pt_t n2_n [2];
  pt_t d2_n [2];
  pt_t q2 [2];
  pt_t n2 [2];
  pt_t d2 [2];
  logic [2*SITE_W-1:0] site2;
  logic v2;

  always_comb begin
    cd = '0;
    pxw = '0;
    pyw = '0;
    tw = '0;
    y1 = '0;
    x1 = '0;
    yel = '0;
    fix = 1'b0;
    for (int i = 0; i < 2; i++) begin
      cd = c1_dl[MD_LAT-1][i];
      pxw = wide_t'(cd.px);
      pyw = wide_t'(cd.py);
      tw = wide_t'(quo1[i]);
      c2_n[i] = '0;
      c2_n[i].frame = cd.frame;
      c2_n[i].xb = cd.px;
      c2_n[i].x_mid = pxw;
      c2_n[i].y_mid = pyw;
      q2_n[i] = '0;
      n2_n[i] = cd.n2;
      d2_n[i] = cd.d2;
      unique case (cd.kind)
        K_FIN: begin
          y1 = cd.xout ? pyw + tw : pyw;
          x1 = cd.xout ? wide_t'(cd.xedge) : pxw;
          fix = cd.xout ? ((y1 < 0) || (y1 > myw)) : cd.yout;
          yel = (y1 < 0) ? '0 : myw;
          c2_n[i].frame = cd.xout | cd.yout;
          c2_n[i].x_mid = x1;
          if (fix) begin
            c2_n[i].y_mid = yel;
            c2_n[i].use2 = (cd.d2 != 0);
            q2_n[i] = pt_t'(yel - pyw);
          end else begin
            c2_n[i].y_mid = y1;
          end
        end
        K_SP: begin
          if (pyw > tw) begin
            c2_n[i].x_mid = '0;
            c2_n[i].y_mid = pyw - tw;
          end else begin
            c2_n[i].use2 = 1'b1;
            c2_n[i].sub = 1'b1;
            c2_n[i].y_mid = '0;
            q2_n[i] = cd.py;
          end
        end
        K_SN: begin
          if (myw - pyw > tw) begin
            c2_n[i].x_mid = '0;
            c2_n[i].y_mid = pyw + tw;
          end else begin
            c2_n[i].use2 = 1'b1;
            c2_n[i].y_mid = myw;
            q2_n[i] = pt_t'(myw - pyw);
          end
        end
        K_EP: begin
          if (myw - pyw > tw) begin
            c2_n[i].x_mid = mxw;
            c2_n[i].y_mid = pyw + tw;
          end else begin
            c2_n[i].use2 = 1'b1;
            c2_n[i].y_mid = myw;
            q2_n[i] = pt_t'(myw - pyw);
          end
        end
        K_EN: begin
          if (pyw + tw > 0) begin
            c2_n[i].x_mid = mxw;
            c2_n[i].y_mid = pyw + tw;
          end else begin
            c2_n[i].use2 = 1'b1;
            c2_n[i].y_mid = '0;
            q2_n[i] = -cd.py;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1_dl[MD_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    c2 <= c2_n;
    site2 <= s1_dl[MD_LAT-1];
    for (int i = 0; i < 2; i++) begin
      q2[i] <= q2_n[i];
      n2[i] <= n2_n[i];
      d2[i] <= d2_n[i];
    end
  end

  // Second multiply-divide pass.
  quo_t quo2 [2];
  for (genvar g = 0; g < 2; g++) begin : g_md2
    vefc_muldiv u_md2 (
      .clk (clk),
      .q   (q2[g]),
      .n   (n2[g]),
      .d   (d2[g]),
      .quo (quo2[g])
    );
  end

  ctx2_t [1:0] c2_dl [MD_LAT];
  logic [2*SITE_W-1:0] s2_dl [MD_LAT];
  logic [MD_LAT-1:0] v2_dl;

  always_ff @(posedge clk) begin
    c2_dl[0] <= c2;
    s2_dl[0] <= site2;
    for (int i = 1; i < MD_LAT; i++) begin
      c2_dl[i] <= c2_dl[i-1];
      s2_dl[i] <= s2_dl[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2_dl <= '0;
    end else begin
      v2_dl <= {v2_dl[MD_LAT-2:0], v2};
    end
  end

  // Final coordinates, saturated to the output range.
  ctx2_t cf;
  wide_t xbw, q2w, xw;
  logic signed [COORD_W-1:0] xf_n [2];
  logic signed [COORD_W-1:0] yf_n [2];
  logic signed [COORD_W-1:0] xf [2];
  logic signed [COORD_W-1:0] yf [2];
  logic [1:0] frame_n, frame_f;
  logic [2*SITE_W-1:0] site3;
  logic v3;

  always_comb begin
    cf = '0;
    xbw = '0;
    q2w = '0;
    xw = '0;
    for (int i = 0; i < 2; i++) begin
      cf = c2_dl[MD_LAT-1][i];
      xbw = wide_t'(cf.xb);
      q2w = wide_t'(quo2[i]);
      if (cf.use2) begin
        xw = cf.sub ? xbw - q2w : xbw + q2w;
      end else begin
        xw = cf.x_mid;
      end
      xf_n[i] = sat32(xw);
      yf_n[i] = sat32(cf.y_mid);
      frame_n[i] = cf.frame;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2_dl[MD_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    site3 <= s2_dl[MD_LAT-1];
    frame_f <= frame_n;
    for (int i = 0; i < 2; i++) begin
      xf[i] <= xf_n[i];
      yf[i] <= yf_n[i];
    end
  end

  // Output register.
  logic inside_n;

  always_comb begin
    inside_n = 1'b1;
    for (int i = 0; i < 2; i++) begin
      if ((xf[i] < 0) || (pt_t'(xf[i]) > mx) || (yf[i] < 0) || (pt_t'(yf[i]) > my)) begin
        inside_n = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v3;
    end
  end

  always_ff @(posedge clk) begin
    start_x <= xf[0];
    start_y <= yf[0];
    end_x <= xf[1];
    end_y <= yf[1];
    start_site <= frame_f[0] ? {SITE_W{1'b1}} : site3[SITE_W-1:0];
    end_site <= frame_f[1] ? {SITE_W{1'b1}} : site3[2*SITE_W-1:SITE_W];
    inside_res <= inside_n;
  end

endmodule

FILE: design/vefc_muldiv.sv
// Pipelined signed (q * n) / d with saturated product and quotient truncated toward zero.
module vefc_muldiv import vefc_pkg::*; (
  input  logic clk,
  input  pt_t  q,
  input  pt_t  n,
  input  pt_t  d,
  output quo_t quo
);

  localparam int LO_W = 17;
  localparam int HI_W = MAG_W - LO_W;
  localparam int PROD_W = 2 * MAG_W;
  localparam logic [PROD_W:0] PROD_SAT = {{(PROD_W + 1 - NUM_W){1'b0}}, {NUM_W{1'b1}}};

  pt_t qa, na, da;
  logic [MAG_W-1:0] qm, nm, dm;
  logic sg;

  assign qa = q[PT_W-1] ? -q : q;
  assign na = n[PT_W-1] ? -n : n;
  assign da = d[PT_W-1] ? -d : d;
  assign qm = qa[MAG_W-1:0];
  assign nm = na[MAG_W-1:0];
  assign dm = da[MAG_W-1:0];
  assign sg = q[PT_W-1] ^ n[PT_W-1] ^ d[PT_W-1];

  logic [LO_W+MAG_W-1:0] pl;
  logic [HI_W+MAG_W-1:0] ph;
  logic [MAG_W-1:0] dm_a;
  logic sg_a;

  always_ff @(posedge clk) begin
    pl <= qm[LO_W-1:0] * nm;
    ph <= qm[MAG_W-1:LO_W] * nm;
    dm_a <= dm;
    sg_a <= sg;
  end

  logic [PROD_W:0] psum;
  assign psum = (PROD_W + 1)'(pl) + ((PROD_W + 1)'(ph) << LO_W);

  logic [NUM_W-1:0] nq [NUM_W+1];
  logic [MAG_W-1:0] rem [NUM_W+1];
  logic [MAG_W-1:0] dv [NUM_W+1];
  logic sgs [NUM_W+1];

  always_ff @(posedge clk) begin
    nq[0] <= (psum > PROD_SAT) ? {NUM_W{1'b1}} : psum[NUM_W-1:0];
    rem[0] <= '0;
    dv[0] <= dm_a;
    sgs[0] <= sg_a;
  end

  for (genvar k = 0; k < NUM_W; k++) begin : g_step
    logic [MAG_W:0] trial, diff;
    logic ge;
    assign trial = {rem[k], nq[k][NUM_W-1]};
    assign ge = trial >= {1'b0, dv[k]};
    assign diff = trial - {1'b0, dv[k]};
    always_ff @(posedge clk) begin
      rem[k+1] <= ge ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
      nq[k+1] <= {nq[k][NUM_W-2:0], ge};
      dv[k+1] <= dv[k];
      sgs[k+1] <= sgs[k];
    end
  end

  always_ff @(posedge clk) begin
    quo <= sgs[NUM_W] ? -quo_t'({1'b0, nq[NUM_W]}) : quo_t'({1'b0, nq[NUM_W]});
  end

endmodule

FILE: design/vefc_check.sv
// Port-level checker of the edge clipper and its bind to the top level.
module vefc_check import vefc_pkg::*; (
  input logic                      clk,
  input logic                      rst,
  input logic                      cfg_valid,
  input logic                      cfg_ready,
  input logic                      start,
  input logic                      busy,
  input logic                      done,
  input logic                      inside_res,
  input logic signed [COORD_W-1:0] start_x,
  input logic signed [COORD_W-1:0] start_y,
  input logic signed [COORD_W-1:0] end_x,
  input logic signed [COORD_W-1:0] end_y
);

  a_no_done_after_reset: assert property (@(posedge clk) rst |=> !done)
    else $error("done raised right after reset");

  a_start_taken: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("item refused while pipeline should accept every cycle");

  a_inside_nonneg: assert property (@(posedge clk) disable iff (rst)
      done && inside_res |-> !start_x[COORD_W-1] && !start_y[COORD_W-1] &&
                             !end_x[COORD_W-1] && !end_y[COORD_W-1])
    else $error("inside flag set with a negative coordinate");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg_valid |-> cfg_ready)
    else $error("configuration write stalled");

endmodule

bind voronoi_edge_frame_clipper vefc_check u_vefc_check (
  .clk        (clk),
  .rst        (rst),
  .cfg_valid  (cfg_valid),
  .cfg_ready  (cfg_ready),
  .start      (start),
  .busy       (busy),
  .done       (done),
  .inside_res (inside_res),
  .start_x    (start_x),
  .start_y    (start_y),
  .end_x      (end_x),
  .end_y      (end_y)
);

FILE: bench/voronoi_edge_frame_clipper_test.sv
// Self-checking testbench for the Voronoi edge frame clipper with a built-in clipping predictor.
`timescale 1ns / 100ps

module voronoi_edge_frame_clipper_test;
  import vefc_pkg::*;

  localparam longint MAXL = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam int FRAC = DEF_COORD_FRAC_BITS;
  localparam int SW = DEF_SITE_INDEX_BITS + 1;
  localparam int DRAIN_CYCLES = 160;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    bit sp;
    int sx;
    int sy;
    logic signed [SW-1:0] ss;
    bit ep;
    int ex;
    int ey;
    logic signed [SW-1:0] es;
    logic signed [LINE_W-1:0] a;
    logic signed [LINE_W-1:0] b;
  } edge_item_t;

  typedef struct {
    int sx;
    int sy;
    int ex;
    int ey;
    logic signed [SW-1:0] ss;
    logic signed [SW-1:0] es;
    bit in_frame;
  } clip_res_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [FRAME_W-1:0] cfg_data = '0;
  logic start = 0;
  logic busy;
  logic start_present = 0;
  logic signed [COORD_W-1:0] start_x_in = '0;
  logic signed [COORD_W-1:0] start_y_in = '0;
  logic signed [SW-1:0] start_site_in = '0;
  logic end_present = 0;
  logic signed [COORD_W-1:0] end_x_in = '0;
  logic signed [COORD_W-1:0] end_y_in = '0;
  logic signed [SW-1:0] end_site_in = '0;
  logic signed [LINE_W-1:0] line_a = '0;
  logic signed [LINE_W-1:0] line_b = '0;
  logic done;
  logic signed [COORD_W-1:0] start_x, start_y, end_x, end_y;
  logic signed [SW-1:0] start_site, end_site;
  logic inside_res;

  clip_res_t clipped_q[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int gap_pct = 0;
  logic [FRAME_W-1:0] frame_x = FRAME_RESET;
  logic [FRAME_W-1:0] frame_y = FRAME_RESET;

  voronoi_edge_frame_clipper dut (.*);

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic longint mul_sat(longint a, longint b);
    longint unsigned ua, ub, p;
    bit neg;
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    neg = (a < 0) != (b < 0);
    if (ua != 0 && ub > longint'(MAXL) / ua) return neg ? -MAXL : MAXL;
    p = ua * ub;
    return neg ? -longint'(p) : longint'(p);
  endfunction

  function automatic longint add_sat(longint a, longint b);
    if (b > 0 && a > MAXL - b) return MAXL;
    if (b < 0 && a < -MAXL - b) return -MAXL;
    return a + b;
  endfunction

  function automatic longint scale(longint q, longint n, longint m);
    return mul_sat(q, n) / m;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  task automatic slide_in(inout longint px, inout longint py, inout longint site,
                          input longint dx, input longint dy, input longint mx,
                          input longint my);
    longint x1, y1, ye;
    bit fix_y;
    x1 = px;
    y1 = py;
    fix_y = 0;
    if (px < 0 || px > mx) begin
      ye = (px < 0) ? 0 : mx;
      y1 = add_sat(py, scale(ye - px, dy, dx));
      x1 = ye;
      site = -1;
      if (y1 < 0 || y1 > my) fix_y = 1;
    end else if (py < 0 || py > my) begin
      site = -1;
      fix_y = 1;
    end
    if (fix_y) begin
      ye = (y1 < 0) ? 0 : my;
      if (dy != 0) x1 = add_sat(px, scale(ye - py, dx, dy));
      y1 = ye;
    end
    px = x1;
    py = y1;
  endtask

  task automatic clip_edge(input edge_item_t e, output bit has, output clip_res_t r);
    longint xs, ys, ss, xe, ye, es, a, b, na, t, mx, my;
    xs = e.sx; ys = e.sy; ss = e.ss;
    xe = e.ex; ye = e.ey; es = e.es;
    a = e.a; b = e.b; na = -a;
    mx = longint'(frame_x) << FRAC;
    my = longint'(frame_y) << FRAC;
    has = e.sp || e.ep;
    r = '{default: 0};
    if (!has) return;
    if (e.sp && e.ep) begin
      if (xs == xe) begin
        if (ys < 0) begin ys = 0; ss = -1; end
        else if (ys > my) begin ys = my; ss = -1; end
        if (ye < 0) begin ye = 0; es = -1; end
        else if (ye > my) begin ye = my; es = -1; end
      end else begin
        t = ye - ys;
        na = xe - xs;
        slide_in(xs, ys, ss, na, t, mx, my);
        slide_in(xe, ye, es, na, t, mx, my);
      end
    end else if (!e.sp) begin
      ss = -1;
      if (b == 0) begin xs = xe; ys = my; end
      else if (a == 0) begin xs = 0; ys = ye; end
      else if ((na > 0) == (b > 0)) begin
        t = scale(xe, na, b);
        if (ye > t) begin xs = 0; ys = add_sat(ye, -t); end
        else begin xs = add_sat(xe, -scale(ye, b, na)); ys = 0; end
      end else begin
        t = scale(-xe, na, b);
        if (my - ye > t) begin xs = 0; ys = add_sat(ye, t); end
        else begin xs = add_sat(xe, scale(my - ye, b, na)); ys = my; end
      end
    end else begin
      es = -1;
      if (b == 0) begin xe = xs; ye = 0; end
      else if (a == 0) begin xe = mx; ye = ys; end
      else if ((na > 0) == (b > 0)) begin
        t = scale(mx - xs, na, b);
        if (my - ys > t) begin xe = mx; ye = add_sat(ys, t); end
        else begin xe = add_sat(xs, scale(my - ys, b, na)); ye = my; end
      end else begin
        t = -scale(mx - xs, na, b);
        if (ys > t) begin xe = mx; ye = add_sat(ys, -t); end
        else begin xe = add_sat(xs, scale(-ys, b, na)); ye = 0; end
      end
    end
    xs = clamp32(xs); ys = clamp32(ys);
    xe = clamp32(xe); ye = clamp32(ye);
    r.sx = int'(xs); r.sy = int'(ys); r.ex = int'(xe); r.ey = int'(ye);
    r.ss = SW'(ss); r.es = SW'(es);
    r.in_frame = xs >= 0 && xs <= mx && xe >= 0 && xe <= mx &&
                 ys >= 0 && ys <= my && ye >= 0 && ye <= my;
  endtask

  always @(posedge clk) begin
    clip_res_t x;
    if (!rst && done) begin
      if (clipped_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result at cycle %0d.", cycles);
      end else begin
        x = clipped_q.pop_front();
        if (start_x !== x.sx || start_y !== x.sy || end_x !== x.ex || end_y !== x.ey ||
            start_site !== x.ss || end_site !== x.es || inside_res !== x.in_frame) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected %0d %0d %0d %0d %0d %0d %0d,",
                     x.sx, x.sy, x.ex, x.ey, x.ss, x.es, x.in_frame,
                     " got %0d %0d %0d %0d %0d %0d %0d",
                     start_x, start_y, end_x, end_y, start_site, end_site, inside_res);
        end
      end
    end
  end

  task automatic send_edge(input edge_item_t e);
    bit has;
    clip_res_t r;
    @(negedge clk);
    while ($urandom_range(99) < gap_pct) begin
      start = 0;
      @(negedge clk);
    end
    start = 1;
    start_present = e.sp; start_x_in = e.sx; start_y_in = e.sy; start_site_in = e.ss;
    end_present = e.ep; end_x_in = e.ex; end_y_in = e.ey; end_site_in = e.es;
    line_a = e.a; line_b = e.b;
    while (busy) @(negedge clk);
    @(posedge clk);
    clip_edge(e, has, r);
    if (has) clipped_q.push_back(r);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    start = 0;
    while (clipped_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_frame(input logic [FRAME_W-1:0] mx, input logic [FRAME_W-1:0] my);
    wait_idle();
    for (int i = 0; i < 2; i++) begin
      @(negedge clk);
      cfg_valid = 1;
      cfg_index = (i == 0) ? REG_FRAME_MAX_X : REG_FRAME_MAX_Y;
      cfg_data = (i == 0) ? mx : my;
      while (!cfg_ready) @(negedge clk);
      @(posedge clk);
      if (i == 0) frame_x = mx;
      else frame_y = my;
    end
    @(negedge clk);
    cfg_valid = 0;
  endtask

  function automatic int rand_coord(input logic [FRAME_W-1:0] lim);
    int span;
    span = (int'(lim) + 1) << FRAC;
    case ($urandom_range(9))
      0, 1, 2, 3: return $urandom_range(span);
      4, 5, 6, 7: return int'($urandom_range(4 * span)) - 2 * span;
      8: return $urandom_range(1) ? 32'sh7FFF_FFFF - $urandom_range(3)
                                  : 32'sh8000_0000 + $urandom_range(3);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [LINE_W-1:0] rand_coef();
    case ($urandom_range(9))
      0: return 0;
      1: return $urandom_range(1) ? 19'sd131072 : -19'sd131072;
      default: return int'($urandom_range(262144)) - 131072;
    endcase
  endfunction

  function automatic edge_item_t rand_edge();
    edge_item_t e;
    int k;
    k = $urandom_range(19);
    e.sp = (k != 0 && k < 13) || k >= 16;
    e.ep = k >= 13 || (k > 0 && k < 10);
    e.sx = rand_coord(frame_x); e.sy = rand_coord(frame_y);
    e.ex = rand_coord(frame_x); e.ey = rand_coord(frame_y);
    if ($urandom_range(9) == 0) e.ex = e.sx;
    if ($urandom_range(9) == 0) e.ey = e.sy;
    e.ss = int'($urandom_range(65536)) - 1;
    e.es = int'($urandom_range(65536)) - 1;
    e.a = rand_coef();
    e.b = rand_coef();
    return e;
  endfunction

  function automatic edge_item_t mk(bit sp, int sx, int sy, bit ep, int ex, int ey,
                                     int a, int b);
    edge_item_t e;
    e = '{sp, sx, sy, 17'sd5, ep, ex, ey, 17'sd65535, a, b};
    return e;
  endfunction

  task automatic test_directed();
    edge_item_t d[$];
    d.push_back(mk(0, 100, 100, 0, 200, 200, 65536, 65536));
    d.push_back(mk(0, 0, 0, 1, 5000, 7000, 65536, 0));
    d.push_back(mk(0, 0, 0, 1, 5000, 7000, 0, 65536));
    d.push_back(mk(0, 0, 0, 1, 5000, 7000, -65536, 65536));
    d.push_back(mk(0, 0, 0, 1, 5000, 7000, 65536, 65536));
    d.push_back(mk(1, 5000, 7000, 0, 0, 0, 65536, 0));
    d.push_back(mk(1, 5000, 7000, 0, 0, 0, 0, 65536));
    d.push_back(mk(1, 5000, 7000, 0, 0, 0, -65536, 32768));
    d.push_back(mk(1, 5000, 7000, 0, 0, 0, 131072, 131072));
    d.push_back(mk(1, -9000, 400000, 0, 0, 0, -131072, 131072));
    d.push_back(mk(0, 0, 0, 1, 300000, -500, 131072, -131072));
    d.push_back(mk(1, 1000, -800, 1, 1000, 300000, 1, 1));
    d.push_back(mk(1, -50000, -800, 1, -50000, 3000, 1, 1));
    d.push_back(mk(1, 100, -900, 1, 90000, -900, 1, 1));
    d.push_back(mk(1, -3000, 500, 1, 300000, 200000, 1, 1));
    d.push_back(mk(1, -3000, -4000, 1, 400000, 300000, 1, 1));
    d.push_back(mk(1, 32'sh8000_0000, 32'sh7FFF_FFFF, 1, 32'sh7FFF_FFFF, 32'sh8000_0000, 1, 1));
    d.push_back(mk(1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 0, 0, -65536, 65536));
    d.push_back(mk(0, 0, 0, 1, 32'sh8000_0000, 32'sh8000_0000, 65536, 65536));
    d.push_back(mk(1, 0, 0, 1, 261888, 261888, 1, 1));
    d[0].ss = -1;
    d[19].ss = -1;
    d[19].es = -1;
    foreach (d[i]) send_edge(d[i]);
  endtask

  task automatic test_random(input int count, input int gap);
    gap_pct = gap;
    for (int i = 0; i < count; i++) begin
      send_edge(rand_edge());
      if (i == count / 2 && gap == 8) wait_idle();
    end
    gap_pct = 0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 0;
    test_directed();
    write_frame(16'hFFFF, 16'd0);
    test_random(50, 8);
    write_frame(16'd0, 16'hFFFF);
    test_random(50, 65);
    write_frame(16'd640, 16'd480);
    test_random(170, 8);
    write_frame(16'd1023, 16'd200);
    test_random(170, 65);
    write_frame($urandom, $urandom);
    test_random(170, 0);
    wait_idle();
    if (mismatches == 0 && clipped_q.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
